FILE: src/hampel_outlier_filter_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef HAMPEL_OUTLIER_FILTER_ASSERT_SVH
`define HAMPEL_OUTLIER_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HOF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hampel_outlier_filter: same-cycle check failed");
`define HOF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hampel_outlier_filter: next-cycle check failed");
`else
`define HOF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HOF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/hof_pkg.sv
// Shared types and constants of the Hampel outlier filter.
package hof_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE = 2'd2;

    localparam int unsigned K_FIELD_W = 5;
    localparam int unsigned THR_W = 12;
    localparam int unsigned HALF_WINDOW_RST = 3;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 12'd768;
    localparam logic WINDOW_MODE_RST = 1'b0;

    // 1.4826 as 14826/10000; deviation side carries 2 * 256 * 10000
    localparam int unsigned SCALE_NUM_W = 14;
    localparam logic [SCALE_NUM_W-1:0] SCALE_NUM = 14'd14826;
    localparam int unsigned DEV_SCALE_W = 23;
    localparam logic [DEV_SCALE_W-1:0] DEV_SCALE = 23'd5120000;
    localparam int unsigned P1_W = THR_W + SCALE_NUM_W;

    typedef struct packed {
        logic clear;
        logic load;
        logic rotate;
        logic to_dev;
    } t_rank_ctl;

endpackage

FILE: src/hof_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hof_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/hof_rank.sv
// Rotating window register line with parallel rank compares for median selection.
module hof_rank #(
    parameter int DEPTH = 33,
    parameter int EW = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hof_pkg::t_rank_ctl         i_ctl,
    input  logic signed [EW-1:0]       i_load_data,
    input  logic signed [EW-1:0]       i_med,
    input  logic [$clog2(DEPTH+1)-1:0] i_r1,
    input  logic [$clog2(DEPTH+1)-1:0] i_r2,
    output logic signed [EW-1:0]       o_sel_lo,
    output logic signed [EW-1:0]       o_sel_hi
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [EW-1:0] r_w [DEPTH];
    logic [DEPTH-1:0]     r_v;
    logic signed [EW-1:0] r_sel_lo;
    logic signed [EW-1:0] r_sel_hi;
    logic signed [EW-1:0] diff [DEPTH];
    logic signed [EW-1:0] absd [DEPTH];
    logic [CW-1:0]        lt;
    logic [CW-1:0]        le;
    logic                 hit_lo;
    logic                 hit_hi;

    always_comb begin
        lt = '0;
        le = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_v[i] && (r_w[i] < r_w[0])) begin
                lt = lt + 1'b1;
            end
            if (r_v[i] && (r_w[i] <= r_w[0])) begin
                le = le + 1'b1;
            end
        end
    end

    assign hit_lo = r_v[0] && (lt <= i_r1) && (i_r1 < le);
    assign hit_hi = r_v[0] && (lt <= i_r2) && (i_r2 < le);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            diff[i] = r_w[i] - i_med;
            absd[i] = diff[i][EW-1] ? -diff[i] : diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.clear) begin
            r_v <= '0;
        end else if (i_ctl.load) begin
            r_v <= {1'b1, r_v[DEPTH-1:1]};
        end else if (i_ctl.rotate) begin
            r_v <= {r_v[0], r_v[DEPTH-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[DEPTH-1] <= i_load_data;
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[DEPTH-1] <= r_w[0];
        end else if (i_ctl.to_dev) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_w[i] <= absd[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate && hit_lo) begin
            r_sel_lo <= r_w[0];
        end
        if (i_ctl.rotate && hit_hi) begin
            r_sel_hi <= r_w[0];
        end
    end

    assign o_sel_lo = r_sel_lo;
    assign o_sel_hi = r_sel_hi;

endmodule

FILE: src/hampel_outlier_filter.sv
// Top level of the recursive Hampel outlier filter.
// A sample that produces no result leaves the filter idle and ready for another
// sample. A judged result is built from window setup to the output register:
// n = up to 2k+1 is the window count, the window is read out of the store RAM
// one entry per cycle, and two full rotations of the rank register line pick
// the median and the MAD. A sample that passes unchanged in interior mode goes
// from setup straight to the output register. A held output register stalls a
// result while it waits on i_ready. The final sample of a series emits up to
// k+1 results in turn and takes no new sample meanwhile.
// Results appear k samples after their input, with one fraction bit; the store RAM
// needs no clearing after reset.
`include "hampel_outlier_filter_assert.svh"
module hampel_outlier_filter #(
    parameter int HALF_MAX = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_end_of_series,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [SAMPLE_BITS:0]      o_value,
    output logic                             o_is_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hof_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hof_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = 2 * HALF_MAX + 1;
    localparam int AW = $clog2(DEPTH);
    localparam int KW = $clog2(HALF_MAX + 1);
    localparam int SEEN_CAP = 3 * HALF_MAX + 1;
    localparam int SW = $clog2(SEEN_CAP + 1);
    localparam int VW = SAMPLE_BITS + 1;
    localparam int EW = SAMPLE_BITS + 2;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PD_W = VW + hof_pkg::DEV_SCALE_W;
    localparam int P2_W = hof_pkg::P1_W + EW;
    localparam int HW_RST = (hof_pkg::HALF_WINDOW_RST > HALF_MAX) ? HALF_MAX
                                                                  : hof_pkg::HALF_WINDOW_RST;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_CUR   = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_PASS  = 4'd4;
    localparam logic [3:0] S_DEV   = 4'd5;
    localparam logic [3:0] S_MAD   = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [AW-1:0] back);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, back};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]            r_state;
    logic [KW-1:0]         r_cfg_k;
    logic [hof_pkg::THR_W-1:0] r_thr;
    logic                  r_cfg_mode;
    logic [KW-1:0]         r_k;
    logic                  r_mode;
    logic [SW-1:0]         r_seen;
    logic [AW-1:0]         r_head;
    logic [SW-1:0]         r_pos;
    logic                  r_end;
    logic [KW-1:0]         r_d;
    logic [AW-1:0]         r_lo;
    logic [AW-1:0]         r_hi;
    logic [CW-1:0]         r_n;
    logic                  r_pass;
    logic [AW-1:0]         r_t;
    logic [AW-1:0]         r_step;
    logic                  r_phase;
    logic signed [VW-1:0]  r_cur;
    logic signed [VW-1:0]  r_med;
    logic [EW-1:0]         r_mad;
    logic [VW-1:0]         r_dev;
    logic [hof_pkg::P1_W-1:0] r_p1;
    logic [PD_W-1:0]       r_pd;
    logic [P2_W-1:0]       r_p2;
    logic signed [VW-1:0]  r_res;
    logic                  r_out_valid;
    logic signed [VW-1:0]  r_out_value;
    logic                  r_out_last;

    logic                  accept;
    logic [KW-1:0]         k_eff;
    logic [KW-1:0]         d_lo;
    logic [KW:0]           dk;
    logic [AW-1:0]         hi_c;
    logic                  pass_c;
    logic [AW-1:0]         rd_back;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic signed [VW-1:0]  mem_wdata;
    logic signed [VW-1:0]  mem_rdata;
    hof_pkg::t_rank_ctl    rank_ctl;
    logic signed [EW-1:0]  sel_lo;
    logic signed [EW-1:0]  sel_hi;
    logic [CW-1:0]         rank_r1;
    logic [CW-1:0]         rank_r2;
    logic signed [EW:0]    med_sum;
    logic signed [VW-1:0]  med_c;
    logic signed [EW-1:0]  cur_diff;
    logic                  outlier;
    logic                  emit_go;
    logic                  last_emit;
    logic [KW-1:0]         cfg_k_sat;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign k_eff = (r_seen == '0) ? r_cfg_k : r_k;
    assign emit_go = !r_out_valid || i_ready;
    assign last_emit = (r_state == S_EMIT) && emit_go && r_end && (r_d == '0);

    assign cfg_k_sat = (32'(i_cfg_data[hof_pkg::K_FIELD_W-1:0]) > HALF_MAX) ? KW'(HALF_MAX)
                       : KW'(i_cfg_data[hof_pkg::K_FIELD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k <= KW'(HW_RST);
            r_thr <= hof_pkg::THRESHOLD_RST;
            r_cfg_mode <= hof_pkg::WINDOW_MODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hof_pkg::CFG_HALF_WINDOW: r_cfg_k <= cfg_k_sat;
                hof_pkg::CFG_THRESHOLD:   r_thr <= i_cfg_data[hof_pkg::THR_W-1:0];
                hof_pkg::CFG_WINDOW_MODE: r_cfg_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign d_lo = (r_d > r_k) ? (r_d - r_k) : '0;
    assign dk = (KW+1)'(r_d) + (KW+1)'(r_k);
    assign hi_c = (dk > r_pos) ? AW'(r_pos) : AW'(dk);
    assign pass_c = r_mode && !((r_d >= r_k) && (r_pos >= dk));

    always_comb begin
        unique case (r_state)
            S_CUR:   rd_back = r_lo;
            S_LOAD:  rd_back = r_t + 1'b1;
            default: rd_back = AW'(r_d);
        endcase
    end
    assign rd_addr = f_slot(r_head, rd_back);

    assign med_sum = {sel_lo[EW-1], sel_lo} + {sel_hi[EW-1], sel_hi};
    assign med_c = med_sum[VW:1];
    assign cur_diff = {r_cur[VW-1], r_cur} - {r_med[VW-1], r_med};
    assign outlier = P2_W'(r_pd) > r_p2;

    assign mem_we = (accept) || ((r_state == S_CMP) && outlier);
    assign mem_waddr = (r_state == S_IDLE) ? r_head : f_slot(r_head, AW'(r_d));
    assign mem_wdata = (r_state == S_IDLE) ? {i_sample, 1'b0} : r_med;

    assign rank_r1 = (r_n - 1'b1) >> 1;
    assign rank_r2 = r_n >> 1;

    always_comb begin
        rank_ctl = '0;
        rank_ctl.clear = (r_state == S_CUR) && !r_pass;
        rank_ctl.load = (r_state == S_LOAD);
        rank_ctl.rotate = (r_state == S_PASS);
        rank_ctl.to_dev = (r_state == S_DEV);
    end

    hof_ram #(
        .WIDTH(VW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(rd_addr),
        .o_rdata(mem_rdata)
    );

    hof_rank #(
        .DEPTH(DEPTH),
        .EW   (EW)
    ) u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rank_ctl),
        .i_load_data({mem_rdata[VW-1], mem_rdata}),
        .i_med      ({med_c[VW-1], med_c}),
        .i_r1       (rank_r1),
        .i_r2       (rank_r2),
        .o_sel_lo   (sel_lo),
        .o_sel_hi   (sel_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen <= '0;
            r_head <= '0;
            r_k <= '0;
            r_mode <= 1'b0;
            r_end <= 1'b0;
            r_d <= '0;
            r_phase <= 1'b0;
            r_step <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_seen == '0) begin
                            r_k <= r_cfg_k;
                            r_mode <= r_cfg_mode;
                        end
                        r_pos <= r_seen;
                        r_end <= i_end_of_series;
                        if (i_end_of_series) begin
                            r_d <= (r_seen < k_eff) ? KW'(r_seen) : k_eff;
                            r_state <= S_SETUP;
                        end else if (r_seen >= k_eff) begin
                            r_d <= k_eff;
                            r_state <= S_SETUP;
                        end else begin
                            r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                            if (r_seen < SW'(SEEN_CAP)) begin
                                r_seen <= r_seen + 1'b1;
                            end
                        end
                    end
                end
                S_SETUP: begin
                    r_lo <= AW'(d_lo);
                    r_hi <= hi_c;
                    r_n <= CW'(hi_c) - CW'(d_lo) + 1'b1;
                    r_pass <= pass_c;
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    r_cur <= mem_rdata;
                    r_phase <= 1'b0;
                    r_step <= '0;
                    if (r_pass) begin
                        r_res <= mem_rdata;
                        r_state <= S_EMIT;
                    end else begin
                        r_t <= r_lo;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_t == r_hi) begin
                        r_state <= S_PASS;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_PASS: begin
                    if (r_step == AW'(DEPTH - 1)) begin
                        r_state <= r_phase ? S_MAD : S_DEV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DEV: begin
                    r_med <= med_c;
                    r_phase <= 1'b1;
                    r_step <= '0;
                    r_state <= S_PASS;
                end
                S_MAD: begin
                    r_mad <= sel_lo[EW-1:0] + sel_hi[EW-1:0];
                    r_dev <= cur_diff[EW-1] ? VW'(-cur_diff) : VW'(cur_diff);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1 <= hof_pkg::P1_W'(r_thr) * hof_pkg::P1_W'(hof_pkg::SCALE_NUM);
                    r_pd <= PD_W'(r_dev) * PD_W'(hof_pkg::DEV_SCALE);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2 <= P2_W'(r_p1) * P2_W'(r_mad);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_res <= outlier ? r_med : r_cur;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (r_end) begin
                            if (r_d == '0) begin
                                r_seen <= '0;
                                r_head <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_d <= r_d - 1'b1;
                                r_state <= S_SETUP;
                            end
                        end else begin
                            r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                            if (r_seen < SW'(SEEN_CAP)) begin
                                r_seen <= r_seen + 1'b1;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && emit_go) begin
            r_out_value <= r_res;
            r_out_last <= last_emit;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_is_last = r_out_last;

    `HOF_ASSERT_IMP(a_head_with_count, i_clk, i_rst_n, r_seen == '0, r_head == '0)
    `HOF_ASSERT_IMP(a_load_in_window, i_clk, i_rst_n, r_state == S_LOAD, r_t <= r_hi)
    `HOF_ASSERT_IMP(a_window_size, i_clk, i_rst_n, r_state == S_PASS, r_n - 1'b1 < CW'(DEPTH))
    `HOF_ASSERT_NXT(a_last_flag, i_clk, i_rst_n, last_emit, o_valid && o_is_last)

endmodule

FILE: bench/hampel_outlier_filter_tb.sv
// Self-checking testbench for hampel_outlier_filter: directed and random series against an in-bench predictor.
`timescale 1ns / 1ps
module hampel_outlier_filter_tb;

    localparam int HALF_MAX = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int DEPTH = 2 * HALF_MAX + 1;
    localparam int SEEN_CAP = 3 * HALF_MAX + 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          eos;
    } t_sample_beat;

    typedef struct {
        logic signed [SAMPLE_BITS:0] val;
        logic                        last;
    } t_filtered_beat;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          i_end_of_series;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS:0]   o_value;
    logic                          o_is_last;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [hof_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [hof_pkg::CFG_DATA_W-1:0] i_cfg_data;

    hampel_outlier_filter #(.HALF_MAX(HALF_MAX), .SAMPLE_BITS(SAMPLE_BITS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sample(i_sample), .i_end_of_series(i_end_of_series),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_is_last(o_is_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    t_sample_beat   pending_samples[$];
    t_filtered_beat expected_outputs[$];

    // predictor state
    longint      win_store[DEPTH];
    int unsigned seen_cnt;
    int unsigned head_idx;
    int unsigned cfg_k;
    int unsigned cfg_thr;
    int unsigned cfg_mode;
    int unsigned act_k;
    int unsigned act_mode;
    int unsigned act_pos;

    int errors;
    int n_samples;
    int n_outputs;
    int n_replaced;
    int n_series;
    int cycle_cnt;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned slot_of(int unsigned back);
        return (head_idx + DEPTH - back) % DEPTH;
    endfunction

    function automatic longint judge_sample(int unsigned d);
        longint      w[DEPTH];
        longint      a[DEPTH];
        longint      cur;
        longint      med;
        longint      mad_q;
        longint      dev;
        longint      tmp;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int          j;
        n = 0;
        cur = win_store[slot_of(d)];
        if (act_mode == 1 && !(d >= act_k && act_pos >= d + act_k))
            return cur;
        lo = (d > act_k) ? d - act_k : 0;
        hi = d + act_k;
        if (hi > act_pos)
            hi = act_pos;
        for (int unsigned t = lo; t <= hi && n < DEPTH; t++) begin
            w[n] = win_store[slot_of(t)];
            n++;
        end
        for (int i = 1; i < n; i++) begin
            tmp = w[i];
            j = i;
            while (j > 0 && w[j-1] > tmp) begin
                w[j] = w[j-1];
                j--;
            end
            w[j] = tmp;
        end
        med = (n % 2) ? w[n/2] : ((w[n/2-1] + w[n/2]) >>> 1);
        for (int i = 0; i < n; i++)
            a[i] = (w[i] >= med) ? w[i] - med : med - w[i];
        for (int i = 1; i < n; i++) begin
            tmp = a[i];
            j = i;
            while (j > 0 && a[j-1] > tmp) begin
                a[j] = a[j-1];
                j--;
            end
            a[j] = tmp;
        end
        mad_q = (n % 2) ? 2 * a[n/2] : a[n/2-1] + a[n/2];
        dev = (cur >= med) ? cur - med : med - cur;
        if (dev * 64'd5120000 > longint'(cfg_thr) * 64'd14826 * mad_q) begin
            cur = med;
            win_store[slot_of(d)] = cur;
            n_replaced++;
        end
        return cur;
    endfunction

    function automatic void push_output(longint v, logic last);
        t_filtered_beat e;
        e.val = v[SAMPLE_BITS:0];
        e.last = last;
        expected_outputs.push_back(e);
    endfunction

    function automatic void predict_sample(t_sample_beat b);
        int unsigned d;
        if (seen_cnt == 0) begin
            act_k = cfg_k;
            act_mode = cfg_mode;
        end
        act_pos = seen_cnt;
        win_store[head_idx] = 2 * longint'(b.smp);
        if (!b.eos) begin
            if (act_pos >= act_k)
                push_output(judge_sample(act_k), 1'b0);
            head_idx = (head_idx + 1) % DEPTH;
            if (seen_cnt < SEEN_CAP)
                seen_cnt++;
        end else begin
            d = (act_pos < act_k) ? act_pos : act_k;
            forever begin
                push_output(judge_sample(d), d == 0);
                if (d == 0)
                    break;
                d--;
            end
            seen_cnt = 0;
            head_idx = 0;
            n_series++;
        end
    endfunction

    // sender: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        t_sample_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                b.smp = i_sample;
                b.eos = i_end_of_series;
                predict_sample(b);
                n_samples++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    b = pending_samples.pop_front();
                    i_valid <= 1'b1;
                    i_sample <= b.smp;
                    i_end_of_series <= b.eos;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    int  stall_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_outputs.size() == 0) begin
                    $display("%0t: unexpected beat value=%0d last=%0b",
                             $time, o_value, o_is_last);
                    errors++;
                end else begin
                    t_filtered_beat e;
                    e = expected_outputs.pop_front();
                    if (o_value !== e.val) begin
                        $display("%0t: value mismatch expected=%0d actual=%0d",
                                 $time, e.val, o_value);
                        errors++;
                    end
                    if (o_is_last !== e.last) begin
                        $display("%0t: is_last mismatch expected=%0b actual=%0b",
                                 $time, e.last, o_is_last);
                        errors++;
                    end
                end
                n_outputs++;
            end
            if (!hold_done && n_outputs >= 40) begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [hof_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[hof_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            hof_pkg::CFG_HALF_WINDOW: cfg_k = ((data & 31) > HALF_MAX) ? HALF_MAX : (data & 31);
            hof_pkg::CFG_THRESHOLD:   cfg_thr = data & 4095;
            hof_pkg::CFG_WINDOW_MODE: cfg_mode = data & 1;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || i_valid || expected_outputs.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_series(int len);
        t_sample_beat b;
        int base;
        base = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < len; i++) begin
            base += $urandom_range(0, 40) - 20;
            case ($urandom_range(0, 9))
                0: b.smp = SAMPLE_BITS'($urandom);
                1: b.smp = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
                default: b.smp = SAMPLE_BITS'(base + $urandom_range(0, 8) - 4);
            endcase
            b.eos = (i == len - 1);
            pending_samples.push_back(b);
        end
    endtask

    task automatic queue_values(int vals[$]);
        t_sample_beat b;
        foreach (vals[i]) begin
            b.smp = SAMPLE_BITS'(vals[i]);
            b.eos = (i == vals.size() - 1);
            pending_samples.push_back(b);
        end
    endtask

    task automatic random_phase(int budget);
        int used;
        int len;
        used = 0;
        while (used < budget) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(2, 2 * cfg_k + 6);
            queue_series(len);
            used += len;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_end_of_series = 1'b0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < DEPTH; i++)
            win_store[i] = 0;
        seen_cnt = 0;
        head_idx = 0;
        cfg_k = hof_pkg::HALF_WINDOW_RST;
        cfg_thr = hof_pkg::THRESHOLD_RST;
        cfg_mode = hof_pkg::WINDOW_MODE_RST;
        act_k = 0;
        act_mode = 0;
        act_pos = 0;
        errors = 0;
        n_samples = 0;
        n_outputs = 0;
        n_replaced = 0;
        n_series = 0;
        cycle_cnt = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, spikes, short series at reset settings
        queue_values('{10, 12, 11, 32767, 13, 12, -32768, 11, 10});
        queue_values('{-1});
        queue_values('{0, 1});
        queue_values('{-32768, 32767, -32768, 32767});
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 1);
        write_reg(hof_pkg::CFG_THRESHOLD, 256);
        write_reg(hof_pkg::CFG_WINDOW_MODE, 0);
        random_phase(12);
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 16);
        write_reg(hof_pkg::CFG_THRESHOLD, 4095);
        write_reg(hof_pkg::CFG_WINDOW_MODE, 1);
        queue_series(52);
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 0);
        write_reg(hof_pkg::CFG_THRESHOLD, 0);
        write_reg(hof_pkg::CFG_WINDOW_MODE, 0);
        random_phase(8);
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 20);
        write_reg(hof_pkg::CFG_THRESHOLD, 512);
        queue_series(18);
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 5);
        write_reg(hof_pkg::CFG_THRESHOLD, 0);
        write_reg(hof_pkg::CFG_WINDOW_MODE, 1);
        random_phase(10);
        wait_idle();

        write_reg(hof_pkg::CFG_HALF_WINDOW, 2);
        write_reg(hof_pkg::CFG_THRESHOLD, $urandom_range(1, 4095));
        write_reg(hof_pkg::CFG_WINDOW_MODE, 0);
        random_phase(10);
        wait_idle();

        $display("Covered %0d samples in %0d series, %0d filtered beats, %0d replaced",
                 n_samples, n_series, n_outputs, n_replaced);
        $display("Window half widths 0 to saturated, both modes, thresholds 0 to 4095");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
